/* rtl/lrf_pkg.sv */
// lrf_pkg: window geometry, widths, payload types and compare-tree functions
// shared by the local range filter modules; depends on nothing else
package lrf_pkg;

  localparam int WIN_W     = 10;
  localparam int WIN_H     = 10;
  localparam int MAX_COLS  = 1024;
  localparam int ROW_LIMIT = 1024;

  localparam int PIX_W = 8;
  localparam int CFG_W = 11;
  localparam int COL_W = $clog2(MAX_COLS);
  localparam int ROW_W = $clog2(ROW_LIMIT);
  // widths that can hold the clamped frame sizes themselves
  localparam int DIM_W  = (CFG_W > COL_W + 1) ? CFG_W : COL_W + 1;
  localparam int RDIM_W = (CFG_W > ROW_W + 1) ? CFG_W : ROW_W + 1;

  // one line store word holds the WIN_H-1 previous rows of one column
  localparam int LS_W = (WIN_H - 1) * PIX_W;

  localparam int RED_MAXN = (WIN_W > WIN_H) ? WIN_W : WIN_H;
  localparam int RED_LOG  = $clog2(RED_MAXN);
  localparam int RED_N    = 1 << RED_LOG;

  localparam logic [CFG_W-1:0] COLS_RESET = CFG_W'(640);
  localparam logic [CFG_W-1:0] ROWS_RESET = CFG_W'(480);

  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_COLS = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_ROWS = REG_IDX_W'(1);

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
  } pixel_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] range_value;
    logic             window_full;
    logic             frame_end;
  } result_t;

  // minimum and maximum of one window column
  typedef struct packed {
    logic [PIX_W-1:0] lo;
    logic [PIX_W-1:0] hi;
  } col_mm_t;

  typedef logic [RED_N-1:0][PIX_W-1:0] red_vec_t;

  // balanced compare trees, unused leaves padded by the caller
  function automatic logic [PIX_W-1:0] tree_min(input red_vec_t v);
    red_vec_t t;
    t = v;
    for (int lvl = 0; lvl < RED_LOG; lvl++) begin
      for (int i = 0; i < RED_N / 2; i++) begin
        t[i] = (t[2*i] < t[2*i+1]) ? t[2*i] : t[2*i+1];
      end
    end
    return t[0];
  endfunction

  function automatic logic [PIX_W-1:0] tree_max(input red_vec_t v);
    red_vec_t t;
    t = v;
    for (int lvl = 0; lvl < RED_LOG; lvl++) begin
      for (int i = 0; i < RED_N / 2; i++) begin
        t[i] = (t[2*i] > t[2*i+1]) ? t[2*i] : t[2*i+1];
      end
    end
    return t[0];
  endfunction

endpackage

/* rtl/lrf_line_store.sv */
// lrf_line_store: line store memory, one word per image column holding the
// previous rows of that column, with read-after-write bypass; uses lrf_pkg
module lrf_line_store (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [lrf_pkg::COL_W-1:0]    rd_addr,
  input  logic                         wr_en,
  input  logic [lrf_pkg::COL_W-1:0]    wr_addr,
  input  logic [lrf_pkg::LS_W-1:0]     wr_data,
  output logic [lrf_pkg::LS_W-1:0]     rd_data
);

  logic [lrf_pkg::LS_W-1:0] mem [lrf_pkg::MAX_COLS];
  logic [lrf_pkg::LS_W-1:0] mem_q;
  logic [lrf_pkg::LS_W-1:0] byp_data;
  logic                     byp;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  // same column written back in the cycle it is read again
  always_ff @(posedge clk) begin
    if (rd_en) begin
      byp      <= wr_en && (wr_addr == rd_addr);
      byp_data <= wr_data;
    end
  end

  assign rd_data = byp ? byp_data : mem_q;

endmodule

/* rtl/lrf_cell.sv */
// lrf_cell: one window column cell holding that column's min and max,
// loaded from its right neighbor on each shift; uses lrf_pkg
module lrf_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             shift,
  input  lrf_pkg::col_mm_t d,
  output lrf_pkg::col_mm_t q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

/* rtl/local_range_filter_top.sv */
// local_range_filter_top: streaming window max minus min over raster pixels
// uses lrf_pkg, lrf_line_store and lrf_cell
//
// Takes one pixel per clock and gives one result per pixel, sustained while
// the output is not stalled, via stages 1 to 3 and the output register. Each
// request reads one word of the line store (one word per column, the WIN_H-1
// previous rows of that column) and writes the shifted word back out of
// stage 1, so the single-port read plus single-port write per clock sets the
// rate. A row of WIN_W cells holds the min and max of each window column and
// shifts by one column per pixel; a compare tree over the cells and a final
// subtract give the range. window_full marks results whose window lies wholly
// inside the image; such a result belongs at its window's top-left corner
// plus half the window size. The line store needs no clearing after reset.
module local_range_filter_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  lrf_pkg::pixel_in_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output lrf_pkg::result_t                out_data,
  input  logic                            cfg_we,
  input  logic [lrf_pkg::REG_IDX_W-1:0]   cfg_index,
  input  logic [lrf_pkg::CFG_W-1:0]       cfg_data
);

  // configuration
  logic [lrf_pkg::CFG_W-1:0]  image_cols;
  logic [lrf_pkg::CFG_W-1:0]  image_rows;
  logic [lrf_pkg::DIM_W-1:0]  eff_cols;
  logic [lrf_pkg::RDIM_W-1:0] eff_rows;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_cols <= lrf_pkg::COLS_RESET;
      image_rows <= lrf_pkg::ROWS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        lrf_pkg::REG_IMAGE_COLS: image_cols <= cfg_data;
        lrf_pkg::REG_IMAGE_ROWS: image_rows <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (image_cols == '0) begin
      eff_cols = lrf_pkg::DIM_W'(1);
    end else if (lrf_pkg::DIM_W'(image_cols) > lrf_pkg::DIM_W'(lrf_pkg::MAX_COLS)) begin
      eff_cols = lrf_pkg::DIM_W'(lrf_pkg::MAX_COLS);
    end else begin
      eff_cols = lrf_pkg::DIM_W'(image_cols);
    end
    if (image_rows == '0) begin
      eff_rows = lrf_pkg::RDIM_W'(1);
    end else if (lrf_pkg::RDIM_W'(image_rows) > lrf_pkg::RDIM_W'(lrf_pkg::ROW_LIMIT)) begin
      eff_rows = lrf_pkg::RDIM_W'(lrf_pkg::ROW_LIMIT);
    end else begin
      eff_rows = lrf_pkg::RDIM_W'(image_rows);
    end
  end

  // pipeline occupancy and flow
  logic v1, v2, v3, v4;
  logic ld2, ld3, ld4;
  logic accept;

  assign ld4      = v3 && (!v4 || out_ready);
  assign ld3      = v2 && (!v3 || ld4);
  assign ld2      = v1 && (!v2 || ld3);
  // no request is taken while in reset
  assign in_ready = !rst && (!v1 || ld2);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= accept || (v1 && !ld2);
      v2 <= ld2 || (v2 && !ld3);
      v3 <= ld3 || (v3 && !ld4);
      v4 <= ld4 || (v4 && !out_ready);
    end
  end

  assign out_valid = v4;

  // position counters
  logic [lrf_pkg::COL_W-1:0]  column_count, column_count_next;
  logic [lrf_pkg::ROW_W-1:0]  row_count, row_count_next;
  logic [lrf_pkg::COL_W-1:0]  col_cur;
  logic [lrf_pkg::ROW_W-1:0]  row_cur;
  logic [lrf_pkg::DIM_W-1:0]  col_inc;
  logic [lrf_pkg::RDIM_W-1:0] row_inc;
  logic                       wrap_col, wrap_row;
  logic                       full_cur, fend_cur;

  always_comb begin
    col_cur  = in_data.frame_start ? '0 : column_count;
    row_cur  = in_data.frame_start ? '0 : row_count;
    col_inc  = lrf_pkg::DIM_W'(col_cur) + lrf_pkg::DIM_W'(1);
    row_inc  = lrf_pkg::RDIM_W'(row_cur) + lrf_pkg::RDIM_W'(1);
    wrap_col = col_inc >= eff_cols;
    wrap_row = row_inc >= eff_rows;
    full_cur = (lrf_pkg::DIM_W'(col_cur) < eff_cols) &&
               (lrf_pkg::RDIM_W'(row_cur) < eff_rows) &&
               (lrf_pkg::DIM_W'(col_cur) >= lrf_pkg::DIM_W'(lrf_pkg::WIN_W - 1)) &&
               (lrf_pkg::RDIM_W'(row_cur) >= lrf_pkg::RDIM_W'(lrf_pkg::WIN_H - 1));
    fend_cur = wrap_col && wrap_row;
    if (wrap_col) begin
      column_count_next = '0;
      row_count_next    = wrap_row ? '0 : row_inc[lrf_pkg::ROW_W-1:0];
    end else begin
      column_count_next = col_inc[lrf_pkg::COL_W-1:0];
      row_count_next    = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  // stage 1: line store word arrives, column min and max
  logic [lrf_pkg::PIX_W-1:0] s1_pixel;
  logic [lrf_pkg::COL_W-1:0] s1_addr;
  logic                      s1_full, s1_fend;

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel <= in_data.pixel;
      s1_addr  <= col_cur;
      s1_full  <= full_cur;
      s1_fend  <= fend_cur;
    end
  end

  logic [lrf_pkg::LS_W-1:0] ls_old;
  logic [lrf_pkg::LS_W-1:0] ls_new;

  // newest previous row goes to the low slot
  assign ls_new = lrf_pkg::LS_W'({ls_old, s1_pixel});

  lrf_line_store u_line_store (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col_cur),
    .wr_en   (ld2),
    .wr_addr (s1_addr),
    .wr_data (ls_new),
    .rd_data (ls_old)
  );

  lrf_pkg::red_vec_t col_lo_v, col_hi_v;
  lrf_pkg::col_mm_t  new_mm;

  always_comb begin
    col_lo_v = '1;
    col_hi_v = '0;
    for (int k = 0; k < lrf_pkg::WIN_H - 1; k++) begin
      col_lo_v[k] = ls_old[k*lrf_pkg::PIX_W +: lrf_pkg::PIX_W];
      col_hi_v[k] = ls_old[k*lrf_pkg::PIX_W +: lrf_pkg::PIX_W];
    end
    col_lo_v[lrf_pkg::WIN_H-1] = s1_pixel;
    col_hi_v[lrf_pkg::WIN_H-1] = s1_pixel;
    new_mm.lo = lrf_pkg::tree_min(col_lo_v);
    new_mm.hi = lrf_pkg::tree_max(col_hi_v);
  end

  // row of column cells, shifting toward index 0
  lrf_pkg::col_mm_t cell_q [lrf_pkg::WIN_W];
  lrf_pkg::col_mm_t cell_d [lrf_pkg::WIN_W];

  for (genvar c = 0; c < lrf_pkg::WIN_W; c++) begin : g_cell
    if (c == lrf_pkg::WIN_W - 1) begin : g_edge
      assign cell_d[c] = new_mm;
    end else begin : g_inner
      assign cell_d[c] = cell_q[c+1];
    end
    lrf_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (ld2),
      .d     (cell_d[c]),
      .q     (cell_q[c])
    );
  end

  // stage 2: window min and max over the cells
  logic s2_full, s2_fend;

  always_ff @(posedge clk) begin
    if (ld2) begin
      s2_full <= s1_full;
      s2_fend <= s1_fend;
    end
  end

  lrf_pkg::red_vec_t        win_lo_v, win_hi_v;
  logic [lrf_pkg::PIX_W-1:0] win_lo, win_hi;

  always_comb begin
    win_lo_v = '1;
    win_hi_v = '0;
    for (int c = 0; c < lrf_pkg::WIN_W; c++) begin
      win_lo_v[c] = cell_q[c].lo;
      win_hi_v[c] = cell_q[c].hi;
    end
    win_lo = lrf_pkg::tree_min(win_lo_v);
    win_hi = lrf_pkg::tree_max(win_hi_v);
  end

  // stage 3: range
  logic [lrf_pkg::PIX_W-1:0] s3_lo, s3_hi;
  logic                      s3_full, s3_fend;

  always_ff @(posedge clk) begin
    if (ld3) begin
      s3_lo   <= win_lo;
      s3_hi   <= win_hi;
      s3_full <= s2_full;
      s3_fend <= s2_fend;
    end
  end

  always_ff @(posedge clk) begin
    if (ld4) begin
      out_data.range_value <= s3_full ? (s3_hi - s3_lo) : '0;
      out_data.window_full <= s3_full;
      out_data.frame_end   <= s3_fend;
    end
  end

endmodule
